// File: rtl/hyperbolic_bound_velocity_update_unit_macros.svh
// assertion macros for the hyperbolic bound velocity update unit
`ifndef HYPERBOLIC_BOUND_VELOCITY_UPDATE_UNIT_MACROS_SVH
`define HYPERBOLIC_BOUND_VELOCITY_UPDATE_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HBVU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbvu check failed");

// next-cycle implication, disabled while in reset
`define HBVU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbvu check failed");

`endif

// File: rtl/hbvu_pkg.sv
package hbvu_pkg;

    // operand stage, partial product stage, product sum stage
    localparam int unsigned PRE_STAGES  = 3;
    // output register
    localparam int unsigned POST_STAGES = 1;

endpackage

// File: rtl/hyperbolic_bound_velocity_update_unit.sv
// hyperbolic bound velocity update: one particle dimension per item
//
// input channel (in_valid/in_ready) carries position, velocity, lower_bound
// and upper_bound; output channel (out_valid/out_ready) carries new_position
// and new_velocity, one result item for every input item, in order.
// all values are signed two's complement of VALUE_WIDTH bits.
//
// from acceptance to out_valid an item passes the operand stage, partial
// products, product sum, one restoring divide step per quotient bit and the
// output register. one item per cycle while out_ready does not stall the
// pipeline; the divide pipeline has VALUE_WIDTH stages.
//
// every stage has its own valid bit and takes a new item whenever it is
// empty or the stage after it moves, so bubbles fill up while the receiver
// stalls and in_ready stays high until every stage holds an item.
// a stalled stage holds its item unchanged; nothing is dropped or repeated.
// reset clears all valid bits; the pipeline is empty and in_ready is high
// right after reset.
`include "hyperbolic_bound_velocity_update_unit_macros.svh"

module hyperbolic_bound_velocity_update_unit #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] position,
    input  logic [VALUE_WIDTH-1:0] velocity,
    input  logic [VALUE_WIDTH-1:0] lower_bound,
    input  logic [VALUE_WIDTH-1:0] upper_bound,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] new_position,
    output logic [VALUE_WIDTH-1:0] new_velocity
);
    import hbvu_pkg::*;

    localparam int unsigned W         = VALUE_WIDTH;
    // half width for the split multiply
    localparam int unsigned H         = (W + 1) / 2;
    localparam int unsigned NSTAGE    = PRE_STAGES + W + POST_STAGES;
    localparam int unsigned PROD_STG  = PRE_STAGES - 1;
    localparam int unsigned OUT_STG   = NSTAGE - 1;

    // ------------------------------------------------------------------
    // per-stage valid bits and the ready chain
    // ------------------------------------------------------------------
    logic valid_reg   [0:NSTAGE-1];
    logic stage_ready [0:NSTAGE-1];

    genvar gi;
    generate
        for (gi = 0; gi < NSTAGE; gi++) begin : g_ctrl
            logic prev_valid;
            if (gi == 0) begin : g_first
                assign prev_valid = in_valid;
            end
            else begin : g_rest
                assign prev_valid = valid_reg[gi-1];
            end
            if (gi == NSTAGE - 1) begin : g_last
                assign stage_ready[gi] = !valid_reg[gi] || out_ready;
            end
            else begin : g_mid
                assign stage_ready[gi] = !valid_reg[gi] || stage_ready[gi+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[gi] <= 1'b0;
                end
                else if (stage_ready[gi])
                begin
                    valid_reg[gi] <= prev_valid;
                end
            end
        end
    endgenerate

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[OUT_STG];

    // ------------------------------------------------------------------
    // stage 0: pick the bound ahead, magnitudes of distance and velocity
    // ------------------------------------------------------------------
    logic [W-1:0] pos0_reg;
    logic         vneg0_reg;
    logic [W-1:0] vmag_reg;
    logic [W-1:0] dmag_reg;

    logic         vneg_in;
    logic         vpos_in;
    logic [W-1:0] bound_in;
    logic [W:0]   diff_in;
    logic [W:0]   diff_abs;
    logic [W-1:0] vmag_next;
    logic [W-1:0] dmag_next;

    always_comb
    begin
        vneg_in   = velocity[W-1];
        vpos_in   = !vneg_in && (velocity != '0);
        bound_in  = vpos_in ? upper_bound : lower_bound;
        diff_in   = {bound_in[W-1], bound_in} - {position[W-1], position};
        diff_abs  = diff_in[W] ? (~diff_in + 1'b1) : diff_in;
        // distance magnitude never exceeds 2^W - 1
        dmag_next = diff_abs[W-1:0];
        // -(most negative) wraps to 2^(W-1), which is right as unsigned
        vmag_next = vneg_in ? (~velocity + 1'b1) : velocity;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            pos0_reg  <= position;
            vneg0_reg <= vneg_in;
            vmag_reg  <= vmag_next;
            dmag_reg  <= dmag_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: four half-width partial products and the divisor
    // ------------------------------------------------------------------
    logic [2*H-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [W:0]     den1_reg;
    logic           dz1_reg;
    logic           vneg1_reg;
    logic [W-1:0]   pos1_reg;

    logic [2*H-1:0] a_ext, b_ext;
    logic [W:0]     den_sum;

    always_comb
    begin
        a_ext   = (2*H)'(vmag_reg);
        b_ext   = (2*H)'(dmag_reg);
        den_sum = {1'b0, dmag_reg} + {1'b0, vmag_reg};
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            pp00_reg  <= (2*H)'(a_ext[H-1:0])   * (2*H)'(b_ext[H-1:0]);
            pp01_reg  <= (2*H)'(a_ext[H-1:0])   * (2*H)'(b_ext[2*H-1:H]);
            pp10_reg  <= (2*H)'(a_ext[2*H-1:H]) * (2*H)'(b_ext[H-1:0]);
            pp11_reg  <= (2*H)'(a_ext[2*H-1:H]) * (2*H)'(b_ext[2*H-1:H]);
            den1_reg  <= den_sum;
            dz1_reg   <= (den_sum == '0);
            vneg1_reg <= vneg0_reg;
            pos1_reg  <= pos0_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: full product, split into first remainder and low bits
    // ------------------------------------------------------------------
    // divide pipeline carry, index k sits in pipeline stage PROD_STG + k
    logic [W:0]   rem_reg  [0:W];
    logic [W-1:0] lo_reg   [0:W];
    logic [W-1:0] quo_reg  [0:W];
    logic [W:0]   den_reg  [0:W];
    logic         dz_reg   [0:W];
    logic         vneg_reg [0:W];
    logic [W-1:0] pos_reg  [0:W];

    logic [4*H-1:0] prod_full;
    logic [2*W-1:0] prod;

    always_comb
    begin
        prod_full = (4*H)'(pp00_reg)
                  + (((4*H)'(pp01_reg) + (4*H)'(pp10_reg)) << H)
                  + ((4*H)'(pp11_reg) << (2*H));
        prod      = prod_full[2*W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[PROD_STG])
        begin
            // the high half is below the divisor since the quotient fits W bits
            rem_reg[0]  <= {1'b0, prod[2*W-1:W]};
            lo_reg[0]   <= prod[W-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den1_reg;
            dz_reg[0]   <= dz1_reg;
            vneg_reg[0] <= vneg1_reg;
            pos_reg[0]  <= pos1_reg;
        end
    end

    // ------------------------------------------------------------------
    // restoring divide, one quotient bit per stage
    // ------------------------------------------------------------------
    generate
        for (gi = 0; gi < W; gi++) begin : g_div
            logic [W+1:0] shifted;
            logic [W+1:0] trial;
            logic         fits;
            logic [W:0]   rem_next;
            logic [W-1:0] quo_next;

            always_comb
            begin
                shifted  = {rem_reg[gi], lo_reg[gi][W-1]};
                trial    = shifted - {1'b0, den_reg[gi]};
                fits     = (shifted >= {1'b0, den_reg[gi]});
                rem_next = fits ? trial[W:0] : shifted[W:0];
                quo_next = {quo_reg[gi][W-2:0], fits};
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[PRE_STAGES + gi])
                begin
                    rem_reg[gi+1]  <= rem_next;
                    lo_reg[gi+1]   <= {lo_reg[gi][W-2:0], 1'b0};
                    quo_reg[gi+1]  <= quo_next;
                    den_reg[gi+1]  <= den_reg[gi];
                    dz_reg[gi+1]   <= dz_reg[gi];
                    vneg_reg[gi+1] <= vneg_reg[gi];
                    pos_reg[gi+1]  <= pos_reg[gi];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // output stage: restore sign, saturating position update
    // ------------------------------------------------------------------
    logic [W-1:0] new_position_reg;
    logic [W-1:0] new_velocity_reg;

    logic [W-1:0] qmag;
    logic [W-1:0] nv_next;
    logic [W:0]   sum_wide;
    logic [W-1:0] np_next;

    always_comb
    begin
        // zero distance and zero velocity give a zero divisor: no motion
        qmag     = dz_reg[W] ? '0 : quo_reg[W];
        nv_next  = vneg_reg[W] ? (~qmag + 1'b1) : qmag;
        sum_wide = {pos_reg[W][W-1], pos_reg[W]} + {nv_next[W-1], nv_next};
        if (sum_wide[W] != sum_wide[W-1])
        begin
            np_next = sum_wide[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            np_next = sum_wide[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[OUT_STG])
        begin
            new_position_reg <= np_next;
            new_velocity_reg <= nv_next;
        end
    end

    assign new_position = new_position_reg;
    assign new_velocity = new_velocity_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `HBVU_ASSERT_NEXT(a_accept_fills_first, clk, rst_n, in_valid && in_ready, valid_reg[0])
    `HBVU_ASSERT_NEXT(a_stall_holds_first, clk, rst_n,
        valid_reg[0] && !stage_ready[0], valid_reg[0] && $stable(vmag_reg))
    `HBVU_ASSERT_IMPLIES(a_rem_below_den, clk, rst_n,
        valid_reg[OUT_STG - 1] && !dz_reg[W], rem_reg[W] < den_reg[W])

endmodule

// File: tb/hbvu_checker.sv
module hbvu_checker #(
    parameter int unsigned W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [W-1:0] position,
    input  logic [W-1:0] velocity,
    input  logic [W-1:0] lower_bound,
    input  logic [W-1:0] upper_bound,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [W-1:0] new_position,
    input  logic [W-1:0] new_velocity,
    output int           fail_count,
    output int           outstanding
);

    typedef struct packed {
        logic [W-1:0] new_position;
        logic [W-1:0] new_velocity;
    } update_t;

    // saturation limits, two guard bits above the value width
    localparam logic signed [W+1:0] SAT_HI = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SAT_LO = {3'b111, {(W-1){1'b0}}};

    update_t pending_updates[$];
    int      errors = 0;

    assign fail_count = errors;

    // damped velocity and saturated position of one dimension
    function automatic update_t damp_dimension(
        input logic [W-1:0] pos_in,
        input logic [W-1:0] vel_in,
        input logic [W-1:0] lo_in,
        input logic [W-1:0] hi_in
    );
        logic signed [W+1:0] pos;
        logic signed [W+1:0] vel;
        logic signed [W+1:0] bound;
        logic signed [W+1:0] reach;
        logic signed [W+1:0] mag;
        logic signed [W+1:0] step;
        logic signed [W+1:0] sum;
        logic [W:0]          dmag;
        logic [W-1:0]        vmag;
        logic [W+1:0]        den;
        logic [2*W:0]        prod;
        logic [2*W:0]        quot;
        update_t             res;
        pos   = (W+2)'($signed(pos_in));
        vel   = (W+2)'($signed(vel_in));
        bound = (vel > 0) ? (W+2)'($signed(hi_in)) : (W+2)'($signed(lo_in));
        reach = bound - pos;
        dmag  = reach[W+1] ? (W+1)'(-reach) : (W+1)'(reach);
        vmag  = vel[W+1] ? W'(-vel) : W'(vel);
        den   = (W+2)'(dmag) + (W+2)'(vmag);
        if (den == 0)
            quot = '0;
        else
        begin
            prod = (2*W+1)'(dmag) * (2*W+1)'(vmag);
            quot = prod / (2*W+1)'(den);
        end
        mag  = quot[W+1:0];
        step = vel[W+1] ? -mag : mag;
        sum  = pos + step;
        if (sum > SAT_HI)
            sum = SAT_HI;
        else if (sum < SAT_LO)
            sum = SAT_LO;
        res.new_position = sum[W-1:0];
        res.new_velocity = step[W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        update_t want;
        if (!rst_n)
        begin
            pending_updates.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_updates.push_back(damp_dimension(position, velocity,
                                                         lower_bound, upper_bound));
            if (out_valid && out_ready)
            begin
                if (pending_updates.size() == 0)
                begin
                    $error("new_position: expected none, actual %h", new_position);
                    errors++;
                end
                else
                begin
                    want = pending_updates.pop_front();
                    if (new_position !== want.new_position)
                    begin
                        $error("new_position: expected %h, actual %h",
                               want.new_position, new_position);
                        errors++;
                    end
                    if (new_velocity !== want.new_velocity)
                    begin
                        $error("new_velocity: expected %h, actual %h",
                               want.new_velocity, new_velocity);
                        errors++;
                    end
                end
            end
            outstanding <= pending_updates.size();
        end
    end

endmodule

// File: tb/tb_top.sv
module tb_top;

    // width of every value field
    localparam int unsigned VW = 32;
    // acceptance to out_valid: operand, partial product, product sum,
    // one divide step per quotient bit, output register
    localparam int unsigned LATENCY = hbvu_pkg::PRE_STAGES + hbvu_pkg::POST_STAGES + VW;
    // cycles with no item moving on either channel before the run is abandoned
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned DIRECTED_ITEMS = 18;

    typedef struct packed {
        logic [VW-1:0] pos;
        logic [VW-1:0] vel;
        logic [VW-1:0] lo;
        logic [VW-1:0] hi;
    } dimension_t;

    // receiver behavior, one per phase
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SLOW,
        READY_HOLD
    } ready_mode_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [VW-1:0] position = '0;
    logic [VW-1:0] velocity = '0;
    logic [VW-1:0] lower_bound = '0;
    logic [VW-1:0] upper_bound = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [VW-1:0] new_position;
    logic [VW-1:0] new_velocity;

    int            fail_count;
    int            outstanding;
    int            idle_cycles = 0;
    int            burst_left = 0;

    ready_mode_t   ready_mode = READY_ALWAYS;
    int            mode_left = 0;
    logic [3:0]    slow_tick = '0;

    dimension_t    directed [DIRECTED_ITEMS];

    hyperbolic_bound_velocity_update_unit #(
        .VALUE_WIDTH(VW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .position    (position),
        .velocity    (velocity),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .new_position(new_position),
        .new_velocity(new_velocity)
    );

    // predicts every result item and compares it as it leaves the block
    hbvu_checker #(
        .W(VW)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .position    (position),
        .velocity    (velocity),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .new_position(new_position),
        .new_velocity(new_velocity),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // value at a random scale, now and then one of the extremes
    function automatic logic [VW-1:0] scaled_value();
        logic signed [VW-1:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end
        return raw >>> $urandom_range(0, VW - 1);
    endfunction

    // mostly ordered bounds with the position between them; the rest
    // hits zero distance, zero velocity, or is plain noise (inverted
    // bounds, position outside, position overflow)
    function automatic dimension_t random_dimension();
        dimension_t         d;
        int                 kind;
        longint             a;
        longint             b;
        longint             t;
        longint unsigned    span;
        longint unsigned    offset;
        kind = $urandom_range(0, 99);
        a = longint'($signed(scaled_value()));
        b = longint'($signed(scaled_value()));
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        span   = b - a;
        offset = {$urandom, $urandom} % (span + 1);
        d.lo   = a[VW-1:0];
        d.hi   = b[VW-1:0];
        t      = a + longint'(offset);
        d.pos  = t[VW-1:0];
        d.vel  = scaled_value();
        if (kind >= 65 && kind < 75)
        begin
            // sit exactly on the bound ahead
            if (d.vel == 0)
                d.vel = $urandom_range(1, 1 << 20);
            d.pos = $signed(d.vel) > 0 ? d.hi : d.lo;
        end
        else if (kind >= 75 && kind < 80)
            d.vel = '0;
        else if (kind >= 80)
        begin
            d.pos = $urandom;
            d.vel = $urandom;
            d.lo  = $urandom;
            d.hi  = $urandom;
        end
        return d;
    endfunction

    // one item on the input channel, with a random gap between bursts;
    // returns at the edge that accepts it
    task automatic push_dimension(input dimension_t d);
        int gap;
        if (burst_left == 0)
        begin
            // a third of the bursts start with no gap at all
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        in_valid    <= 1'b1;
        position    <= d.pos;
        velocity    <= d.vel;
        lower_bound <= d.lo;
        upper_bound <= d.hi;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    // receiver: phases of always ready, random stalls, a slow duty cycle
    // and long holds, so stalls land on every pipeline fill level
    always @(posedge clk or negedge rst_n)
    begin
        ready_mode_t next_mode;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_mode <= READY_ALWAYS;
            mode_left  <= 0;
            slow_tick  <= '0;
        end
        else
        begin
            slow_tick <= slow_tick + 1'b1;
            if (mode_left == 0)
            begin
                next_mode  = ready_mode_t'($urandom_range(0, 3));
                ready_mode <= next_mode;
                mode_left  <= (next_mode == READY_HOLD) ? $urandom_range(10, 80)
                                                        : $urandom_range(40, 300);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                READY_ALWAYS: out_ready <= 1'b1;
                READY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                READY_SLOW:   out_ready <= (slow_tick < 4'd3);
                default:      out_ready <= 1'b0;
            endcase
        end
    end

    // watchdog: no item moving on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // fields: position, velocity, lower bound, upper bound
        directed = '{
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
            // unit distance, unit velocity: quotient truncates to zero
            '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001},
            // largest positive velocity toward the largest upper bound
            '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
            // most negative velocity toward the most negative lower bound
            '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff},
            // zero distance, moving up onto the upper bound
            '{32'h0001_0000, 32'h0000_8000, 32'h0000_0000, 32'h0001_0000},
            // zero velocity with zero distance to the lower bound
            '{32'h0002_0000, 32'h0000_0000, 32'h0002_0000, 32'h0005_0000},
            // zero velocity, lower bound away from the position
            '{32'h0002_0000, 32'h0000_0000, 32'hffff_0000, 32'h0005_0000},
            // inverted bounds
            '{32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 32'h0001_0000},
            // position above the upper bound
            '{32'h0009_0000, 32'h0004_0000, 32'h0000_0000, 32'h0005_0000},
            // position overflow upward, saturates at the top
            '{32'h7fff_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000},
            // position overflow downward, saturates at the bottom
            '{32'h8000_0001, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
            // widest distance there is
            '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
            '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
            '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
            // small negative step, distance of one lsb below
            '{32'h0001_0000, 32'hffff_ffff, 32'h0000_ffff, 32'h0002_0000},
            // ordinary fractional values, moving up and moving down
            '{32'h0001_0000, 32'h0000_8000, 32'h0000_0000, 32'h0002_0000},
            '{32'hfffe_0000, 32'hfffc_0000, 32'hfff0_0000, 32'h0000_0000}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            push_dimension(directed[i]);
        repeat (RANDOM_ITEMS)
            push_dimension(random_dimension());
        in_valid <= 1'b0;

        // drain, then watch a little longer for stray result items;
        // the count is looked at only after it has seen the last item
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (LATENCY + 4) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
